### src/jacobi_eigen_solver_defines.svh
// assertion macros for the jacobi eigen solver checker
`ifndef JACOBI_EIGEN_SOLVER_DEFINES_SVH
`define JACOBI_EIGEN_SOLVER_DEFINES_SVH

// check a property outside of reset
`define JES_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("jes check failed");

// check a property that also spans the reset cycles
`define JES_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("jes reset check failed");

`endif

### src/jes_pkg.sv
// shared types, constants and helper functions of the jacobi eigen solver
package jes_pkg;

   localparam int IDX_W     = 3;
   localparam int VAL_W     = 32;
   localparam int CNT_W     = 16;
   localparam int CX_W      = 40;
   localparam int CZ_W      = 36;
   localparam int CS_W      = 34;
   localparam int MAC_P_W   = VAL_W + CS_W;
   localparam int MAC_ACC_W = MAC_P_W + 2;
   localparam int MAC_SH_W  = MAC_ACC_W - 30;
   localparam int STEP_W    = 5;

   localparam logic [CNT_W-1:0] ITER_RESET = 16'd100;
   localparam logic signed [CZ_W-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [CZ_W-1:0] QUARTER_PI_Q30 = 36'sd843314856;
   localparam logic signed [CX_W-1:0] INV_GAIN_Q30 = 40'sd652032874;
   localparam logic signed [MAC_ACC_W-1:0] HALF_LSB_Q30 = MAC_ACC_W'(64'sd536870912);
   localparam logic signed [MAC_SH_W-1:0] SAT_HI = MAC_SH_W'(32'sh7fffffff);
   localparam logic signed [MAC_SH_W-1:0] SAT_LO = MAC_SH_W'(32'sh80000000);
   localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sd65536;

   localparam logic KIND_EIGVAL = 1'b0;
   localparam logic KIND_EIGVEC = 1'b1;

   // atan(2^-i) in q30, truncated
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
   };

   typedef enum logic [4:0] {
      ST_LOAD, ST_INIT, ST_ROT_CHECK, ST_SCAN, ST_SCAN_TAIL,
      ST_RD_PP, ST_RD_QQ, ST_RD_PQ, ST_RD_END, ST_ANGLE, ST_VEC_WAIT,
      ST_ROT_START, ST_ROT_WAIT, ST_EL_RD_U, ST_EL_RD_W, ST_EL_CAP,
      ST_EL_MAC, ST_EL_WAIT, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
   } state_type;

   typedef enum logic [1:0] {
      PH_MAT_COL, PH_MAT_ROW, PH_VEC_COL
   } phase_type;

   typedef enum logic [2:0] {
      MS_UC, MS_WS, MS_WC, MS_NUS, MS_SUMQ, MS_OUTQ
   } mac_step_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   typedef struct packed {
      logic p_valid;
      logic q_valid;
   } mac_sts_type;

   // round a q30 product sum to q0 and clamp to 32 bits
   function automatic logic signed [VAL_W-1:0] round_sat(
      input logic signed [MAC_ACC_W-1:0] acc);
      logic signed [MAC_ACC_W-1:0] biased;
      logic signed [MAC_SH_W-1:0] shifted;
      biased  = acc + HALF_LSB_Q30;
      shifted = biased[MAC_ACC_W-1:30];
      if (shifted > SAT_HI) return 32'sh7fffffff;
      if (shifted < SAT_LO) return 32'sh80000000;
      return shifted[VAL_W-1:0];
   endfunction

   // magnitude of a signed word
   function automatic logic [VAL_W:0] mag(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W:0] ext;
      ext = {v[VAL_W-1], v};
      return ext[VAL_W] ? (-ext) : ext;
   endfunction

endpackage

### src/jes_req_if.sv
// input channel: one matrix element per word
interface jes_req_if import jes_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] matrix_value;
   logic                    last_element;

   modport source (output valid, matrix_value, last_element, input ready);
   modport sink (input valid, matrix_value, last_element, output ready);
endinterface

### src/jes_rsp_if.sv
// result channel: eigenvalues then eigenvector entries
interface jes_rsp_if import jes_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    result_kind;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [VAL_W-1:0] result_value;
   logic                    last_result;

   modport source (output valid, result_kind, row_index, col_index, result_value,
                   last_result, input ready);
   modport sink (input valid, result_kind, row_index, col_index, result_value,
                 last_result, output ready);
endinterface

### src/jes_ram.sv
// generic single write port ram with registered read
module jes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/jes_cordic.sv
// shared cordic unit, vectoring for the angle and rotation for cos and sin
module jes_cordic import jes_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cordic_cmd_type         cmd,
   input  logic signed [CX_W-1:0] in_x,
   input  logic signed [CX_W-1:0] in_y,
   input  logic signed [CZ_W-1:0] in_z,
   output logic                   done,
   output logic signed [CX_W-1:0] out_x,
   output logic signed [CX_W-1:0] out_y,
   output logic signed [CZ_W-1:0] out_z
);
   localparam logic [STEP_W-1:0] LastStep = STEP_W'(CORDIC_STEPS - 1);

   logic                   busy_ff, done_ff, vec_ff;
   logic [STEP_W-1:0]      step_ff;
   logic signed [CX_W-1:0] x_ff, y_ff;
   logic signed [CZ_W-1:0] z_ff;
   logic signed [CX_W-1:0] x_sh, y_sh;
   logic signed [CZ_W-1:0] ang;
   logic                   turn_pos;

   // one micro-rotation per cycle
   always_comb begin
      x_sh     = x_ff >>> step_ff;
      y_sh     = y_ff >>> step_ff;
      ang      = $signed(CZ_W'(ATAN_Q30[step_ff]));
      turn_pos = vec_ff ? y_ff[CX_W-1] : !z_ff[CZ_W-1];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == LastStep);
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == LastStep) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         step_ff <= '0;
         vec_ff  <= cmd.vectoring;
         if (cmd.vectoring && in_x[CX_W-1]) begin
            x_ff <= -in_x;
            y_ff <= -in_y;
            z_ff <= in_y[CX_W-1] ? -PI_Q30 : PI_Q30;
         end else begin
            x_ff <= in_x;
            y_ff <= in_y;
            z_ff <= cmd.vectoring ? '0 : in_z;
         end
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (turn_pos) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - ang;
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + ang;
         end
      end
   end

   assign done  = done_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
endmodule

### src/jes_mac.sv
// one shared multiplier forming u*c + w*s and w*c - u*s with rounding
module jes_mac import jes_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VAL_W-1:0] u,
   input  logic signed [VAL_W-1:0] w,
   input  logic signed [CS_W-1:0]  c,
   input  logic signed [CS_W-1:0]  s,
   output mac_sts_type             sts,
   output logic signed [VAL_W-1:0] result
);
   logic                        busy_ff;
   mac_step_type                step_ff, step_in;
   logic signed [MAC_P_W-1:0]   prod_ff;
   logic signed [MAC_ACC_W-1:0] acc_ff;
   logic signed [MAC_ACC_W-1:0] prod_ext;
   logic signed [VAL_W-1:0]     mul_a;
   logic signed [CS_W-1:0]      mul_b;

   // operand select for the current step
   always_comb begin
      mul_a = u;
      mul_b = c;
      unique case (step_ff)
         MS_UC:   begin mul_a = u; mul_b = c;  end
         MS_WS:   begin mul_a = w; mul_b = s;  end
         MS_WC:   begin mul_a = w; mul_b = c;  end
         MS_NUS:  begin mul_a = u; mul_b = -s; end
         default: begin mul_a = u; mul_b = c;  end
      endcase
   end

   // step sequence
   always_comb begin
      unique case (step_ff)
         MS_UC:   step_in = MS_WS;
         MS_WS:   step_in = MS_WC;
         MS_WC:   step_in = MS_NUS;
         MS_NUS:  step_in = MS_SUMQ;
         MS_SUMQ: step_in = MS_OUTQ;
         default: step_in = MS_UC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= MS_UC;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= MS_UC;
      end else if (busy_ff) begin
         step_ff <= step_in;
         if (step_ff == MS_OUTQ) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign prod_ext = {{2{prod_ff[MAC_P_W-1]}}, prod_ff};

   // product register then accumulate
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         prod_ff <= mul_a * mul_b;
         unique case (step_ff)
            MS_WS, MS_NUS:  acc_ff <= prod_ext;
            MS_WC, MS_SUMQ: acc_ff <= acc_ff + prod_ext;
            default:        acc_ff <= acc_ff;
         endcase
      end
   end

   assign sts.p_valid = busy_ff && (step_ff == MS_NUS);
   assign sts.q_valid = busy_ff && (step_ff == MS_OUTQ);
   assign result      = round_sat(acc_ff);
endmodule

### src/jacobi_eigen_solver.sv
// top level of the classical jacobi eigenvalue solver
//
// req_chan takes one q16.16 matrix element per word in row-major order; the
// word with last_element set starts the solve. csr_write_enable/csr_write_data
// set the rotation count (reset 100); write it only while the block is idle.
// rsp_chan then returns MATRIX_SIZE eigenvalues followed by the eigenvector
// matrix in row-major order, last_result marking the final word.
// req_chan.ready is high only while loading and stays high for the whole load,
// so each element word is taken as soon as it is valid. After the last element
// the block sets the eigenvector store to identity and runs the rotations. Each
// rotation runs the pivot check, scan and reads, a vectoring CORDIC pass for the
// angle (skipped when the two diagonal entries match), a rotating CORDIC pass for
// cos and sin, and the 3*N element updates, which share one multiplier and one
// ram port per store. Each result word is read, registered and held; a stalled
// word holds until taken, and no further word is read before it is taken.
// Synchronous reset returns to loading with the load position at zero.
module jacobi_eigen_solver import jes_pkg::*; #(
   parameter int MATRIX_SIZE  = 4,
   parameter int CORDIC_STEPS = 24
) (
   input  logic             clock,
   input  logic             reset,
   jes_req_if.sink          req_chan,
   jes_rsp_if.source        rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data
);
   localparam int Cells = MATRIX_SIZE * MATRIX_SIZE;
   localparam int AddrW = $clog2(Cells);
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MATRIX_SIZE - 1);
   localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);

   function automatic logic [AddrW-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
      logic [2*IDX_W-1:0] flat;
      flat = (2*IDX_W)'(row) * (2*IDX_W)'(MATRIX_SIZE) + (2*IDX_W)'(col);
      return flat[AddrW-1:0];
   endfunction

   state_type               state_ff, state_in;
   phase_type               phase_ff;
   logic [AddrW-1:0]        load_ff;
   logic [CNT_W-1:0]        iter_ff, rot_ff;
   logic [IDX_W-1:0]        row_ff, col_ff, elem_ff, piv_p_ff, piv_q_ff;
   logic [IDX_W-1:0]        scan_r_ff, scan_c_ff;
   logic                    scan_v_ff, have_ff, rd_vec_ff, kind_ff;
   logic [VAL_W:0]          best_ff;
   logic signed [VAL_W-1:0] app_ff, aqq_ff, apq_ff, u_ff, w_ff;
   logic signed [CZ_W-1:0]  theta_ff;
   logic signed [CS_W-1:0]  cos_ff, sin_ff;
   logic                    rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;

   logic                    req_fire, rsp_fire, last_cell, last_elem;
   logic [AddrW-1:0]        rd_addr, wr_addr, addr_u, addr_w;
   logic                    rd_vec, mat_we, vec_we;
   logic signed [VAL_W-1:0] wr_data, mat_rd, vec_rd, rdata;
   cordic_cmd_type          cor_cmd;
   logic signed [CX_W-1:0]  cor_x, cor_y, cor_out_x, cor_out_y;
   logic signed [CZ_W-1:0]  cor_z, cor_out_z;
   logic                    cor_done, mac_start;
   mac_sts_type             mac_sts;
   logic signed [VAL_W-1:0] mac_res;
   logic signed [VAL_W:0]   diag_diff;
   logic [VAL_W:0]          rd_mag;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_chan.ready;
   assign last_cell = (row_ff == LastIdx) && (col_ff == LastIdx);
   assign last_elem = (elem_ff == LastIdx);
   assign rdata     = rd_vec_ff ? vec_rd : mat_rd;
   assign rd_mag    = mag(rdata);
   assign diag_diff = {app_ff[VAL_W-1], app_ff} - {aqq_ff[VAL_W-1], aqq_ff};

   // cell pair touched by one element update
   always_comb begin
      if (phase_ff == PH_MAT_ROW) begin
         addr_u = cell_addr(piv_p_ff, elem_ff);
         addr_w = cell_addr(piv_q_ff, elem_ff);
      end else begin
         addr_u = cell_addr(elem_ff, piv_p_ff);
         addr_w = cell_addr(elem_ff, piv_q_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:      if (req_fire && req_chan.last_element) state_in = ST_INIT;
         ST_INIT:      if (last_cell) state_in = ST_ROT_CHECK;
         ST_ROT_CHECK: state_in = (rot_ff == iter_ff) ? ST_OUT_RD : ST_SCAN;
         ST_SCAN:      if (last_cell) state_in = ST_SCAN_TAIL;
         ST_SCAN_TAIL: state_in = ST_RD_PP;
         ST_RD_PP:     state_in = ST_RD_QQ;
         ST_RD_QQ:     state_in = ST_RD_PQ;
         ST_RD_PQ:     state_in = ST_RD_END;
         ST_RD_END:    state_in = ST_ANGLE;
         ST_ANGLE:     state_in = (app_ff == aqq_ff) ? ST_ROT_START : ST_VEC_WAIT;
         ST_VEC_WAIT:  if (cor_done) state_in = ST_ROT_START;
         ST_ROT_START: state_in = ST_ROT_WAIT;
         ST_ROT_WAIT:  if (cor_done) state_in = ST_EL_RD_U;
         ST_EL_RD_U:   state_in = ST_EL_RD_W;
         ST_EL_RD_W:   state_in = ST_EL_CAP;
         ST_EL_CAP:    state_in = ST_EL_MAC;
         ST_EL_MAC:    state_in = ST_EL_WAIT;
         ST_EL_WAIT: begin
            if (mac_sts.q_valid) begin
               state_in = (last_elem && phase_ff == PH_VEC_COL) ? ST_ROT_CHECK
                                                                : ST_EL_RD_U;
            end
         end
         ST_OUT_RD:    state_in = ST_OUT_LD;
         ST_OUT_LD:    state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (rsp_fire) begin
               state_in = (kind_ff == KIND_EIGVEC && last_cell) ? ST_LOAD : ST_OUT_RD;
            end
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   // control outputs: ram ports and unit starts
   always_comb begin
      rd_addr   = '0;
      rd_vec    = 1'b0;
      mat_we    = 1'b0;
      vec_we    = 1'b0;
      wr_addr   = '0;
      wr_data   = req_chan.matrix_value;
      cor_cmd   = '0;
      cor_x     = {{(CX_W-VAL_W-1){diag_diff[VAL_W]}}, diag_diff};
      cor_y     = {{(CX_W-VAL_W-1){apq_ff[VAL_W-1]}}, apq_ff, 1'b0};
      cor_z     = '0;
      mac_start = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            mat_we  = req_fire;
            wr_addr = load_ff;
         end
         ST_INIT: begin
            vec_we  = 1'b1;
            wr_addr = cell_addr(row_ff, col_ff);
            wr_data = (row_ff == col_ff) ? ONE_Q16 : '0;
         end
         ST_SCAN:  rd_addr = cell_addr(row_ff, col_ff);
         ST_RD_PP: rd_addr = cell_addr(piv_p_ff, piv_p_ff);
         ST_RD_QQ: rd_addr = cell_addr(piv_q_ff, piv_q_ff);
         ST_RD_PQ: rd_addr = cell_addr(piv_p_ff, piv_q_ff);
         ST_ANGLE: begin
            cor_cmd.start     = (app_ff != aqq_ff);
            cor_cmd.vectoring = 1'b1;
         end
         ST_ROT_START: begin
            cor_cmd.start = 1'b1;
            cor_x         = INV_GAIN_Q30;
            cor_y         = '0;
            cor_z         = theta_ff;
         end
         ST_EL_RD_U: begin
            rd_addr = addr_u;
            rd_vec  = (phase_ff == PH_VEC_COL);
         end
         ST_EL_RD_W: begin
            rd_addr = addr_w;
            rd_vec  = (phase_ff == PH_VEC_COL);
         end
         ST_EL_MAC: mac_start = 1'b1;
         ST_EL_WAIT: begin
            wr_data = mac_res;
            wr_addr = mac_sts.q_valid ? addr_w : addr_u;
            mat_we  = (mac_sts.p_valid || mac_sts.q_valid) && (phase_ff != PH_VEC_COL);
            vec_we  = (mac_sts.p_valid || mac_sts.q_valid) && (phase_ff == PH_VEC_COL);
         end
         ST_OUT_RD: begin
            rd_addr = (kind_ff == KIND_EIGVEC) ? cell_addr(row_ff, col_ff)
                                               : cell_addr(row_ff, row_ff);
            rd_vec  = (kind_ff == KIND_EIGVEC);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_ff      <= '0;
         rot_ff       <= '0;
         iter_ff      <= ITER_RESET;
         piv_p_ff     <= '0;
         piv_q_ff     <= IDX_W'(1);
         rsp_valid_ff <= 1'b0;
         scan_v_ff    <= 1'b0;
         rd_vec_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vec_ff <= rd_vec;
         scan_v_ff <= (state_ff == ST_SCAN);
         if (csr_write_enable) begin
            iter_ff <= csr_write_data;
         end
         if (state_ff == ST_LOAD && req_fire) begin
            if (req_chan.last_element || load_ff == LastCell) begin
               load_ff <= '0;
            end else begin
               load_ff <= load_ff + 1'b1;
            end
            if (req_chan.last_element) begin
               rot_ff <= '0;
            end
         end
         if (state_ff == ST_EL_WAIT && mac_sts.q_valid && last_elem &&
             phase_ff == PH_VEC_COL) begin
            rot_ff <= rot_ff + 1'b1;
         end
         // pivot search keeps the first largest off-diagonal entry
         if (scan_v_ff && scan_r_ff != scan_c_ff && (!have_ff || rd_mag > best_ff)) begin
            piv_p_ff <= scan_r_ff;
            piv_q_ff <= scan_c_ff;
         end
         if (state_ff == ST_OUT_LD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sequencing counters and datapath registers
   always_ff @(posedge clock) begin
      scan_r_ff <= row_ff;
      scan_c_ff <= col_ff;
      if (scan_v_ff && scan_r_ff != scan_c_ff && (!have_ff || rd_mag > best_ff)) begin
         best_ff <= rd_mag;
         have_ff <= 1'b1;
      end
      unique case (state_ff)
         ST_LOAD: begin
            row_ff <= '0;
            col_ff <= '0;
         end
         ST_INIT, ST_SCAN: begin
            if (last_cell) begin
               row_ff <= '0;
               col_ff <= '0;
            end else if (col_ff == LastIdx) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         ST_ROT_CHECK: begin
            row_ff  <= '0;
            col_ff  <= '0;
            have_ff <= 1'b0;
            kind_ff <= KIND_EIGVAL;
         end
         ST_RD_QQ:  app_ff <= rdata;
         ST_RD_PQ:  aqq_ff <= rdata;
         ST_RD_END: apq_ff <= rdata;
         ST_ANGLE: begin
            theta_ff <= (apq_ff > 0) ? QUARTER_PI_Q30 : -QUARTER_PI_Q30;
         end
         ST_VEC_WAIT: begin
            if (cor_done) begin
               theta_ff <= cor_out_z >>> 1;
            end
         end
         ST_ROT_WAIT: begin
            if (cor_done) begin
               cos_ff   <= cor_out_x[CS_W-1:0];
               sin_ff   <= cor_out_y[CS_W-1:0];
               elem_ff  <= '0;
               phase_ff <= PH_MAT_COL;
            end
         end
         ST_EL_RD_W: u_ff <= rdata;
         ST_EL_CAP:  w_ff <= rdata;
         ST_EL_WAIT: begin
            if (mac_sts.q_valid) begin
               if (last_elem) begin
                  elem_ff <= '0;
                  unique case (phase_ff)
                     PH_MAT_COL: phase_ff <= PH_MAT_ROW;
                     PH_MAT_ROW: phase_ff <= PH_VEC_COL;
                     default:    phase_ff <= PH_MAT_COL;
                  endcase
               end else begin
                  elem_ff <= elem_ff + 1'b1;
               end
            end
         end
         ST_OUT_LD: begin
            rsp_kind_ff  <= kind_ff;
            rsp_row_ff   <= row_ff;
            rsp_col_ff   <= (kind_ff == KIND_EIGVEC) ? col_ff : '0;
            rsp_value_ff <= rdata;
            rsp_last_ff  <= (kind_ff == KIND_EIGVEC) && last_cell;
         end
         ST_OUT_HOLD: begin
            if (rsp_fire) begin
               if (kind_ff == KIND_EIGVAL) begin
                  if (row_ff == LastIdx) begin
                     kind_ff <= KIND_EIGVEC;
                     row_ff  <= '0;
                     col_ff  <= '0;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
               end else if (col_ff == LastIdx) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
         end
         default: begin
            u_ff <= u_ff;
         end
      endcase
   end

   jes_ram #(.WIDTH(VAL_W), .DEPTH(Cells)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (mat_rd)
   );

   jes_ram #(.WIDTH(VAL_W), .DEPTH(Cells)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (vec_rd)
   );

   jes_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_cmd),
      .in_x  (cor_x),
      .in_y  (cor_y),
      .in_z  (cor_z),
      .done  (cor_done),
      .out_x (cor_out_x),
      .out_y (cor_out_y),
      .out_z (cor_out_z)
   );

   jes_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .u      (u_ff),
      .w      (w_ff),
      .c      (cos_ff),
      .s      (sin_ff),
      .sts    (mac_sts),
      .result (mac_res)
   );

   // channel outputs
   assign req_chan.ready        = (state_ff == ST_LOAD);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_kind_ff;
   assign rsp_chan.row_index    = rsp_row_ff;
   assign rsp_chan.col_index    = rsp_col_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.last_result  = rsp_last_ff;
endmodule

### src/jes_checker.sv
// port-level checks for the jacobi eigen solver, bound to the top level
`include "jacobi_eigen_solver_defines.svh"

module jes_checker import jes_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_kind,
   input logic [IDX_W-1:0]        rsp_col,
   input logic signed [VAL_W-1:0] rsp_value,
   input logic                    rsp_last
);
   // a stalled result word holds
   `JES_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
   // no result word shows the cycle after reset
   `JES_ASSERT_RST(a_rsp_reset, reset |=> !rsp_valid)
   // loading and result delivery never overlap
   `JES_ASSERT(a_one_side, !(req_ready && rsp_valid))
   // taking the final word returns the block to loading
   `JES_ASSERT(a_back_to_load, rsp_valid && rsp_ready && rsp_last |=> req_ready)
   // eigenvalue words carry column zero
   `JES_ASSERT(a_eigval_col, rsp_valid && rsp_kind == KIND_EIGVAL |-> rsp_col == '0)
endmodule

bind jacobi_eigen_solver jes_checker u_jes_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.result_kind),
   .rsp_col   (rsp_chan.col_index),
   .rsp_value (rsp_chan.result_value),
   .rsp_last  (rsp_chan.last_result)
);
